[src/spmv_pkg.sv]
// ============================================================================
// spmv_pkg
// Shared types and constants for the CSR sparse matrix-vector multiply block.
// ============================================================================
package spmv_pkg;

    // Default vector store depth
    localparam int VECTOR_DEPTH_DEFAULT = 1024;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 10;
    localparam int SUM_W   = 64;

    // Stream payload widths (packed fields padded to whole bytes)
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NONZERO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY_ROW = 2'd2;

    // Saturation limits of the Q32.32 accumulator
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Command and flags carried from the accept stage to the multiply stage
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             last;
        logic             in_range;
    } spmv_ctrl_t;

endpackage

[src/spmv_ram.sv]
// ============================================================================
// spmv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the entry and register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/csr_sparse_matrix_vector_multiply.sv]
// ============================================================================
// csr_sparse_matrix_vector_multiply
// CSR sparse matrix times dense vector with a saturating Q32.32 row sum.
// ============================================================================
//
//  Channel   Dir  tdata (low bit up)                     tuser / tlast
//  s_axis    in   index[9:0], value[41:10], pad          tuser command, tlast last_in_row
//  m_axis    out  row_number[9:0], row_sum[73:10], pad   tuser saturated
//
//  One beat per cycle in sustained flow, while no row result is held at
//  m_axis. A nonzero reads the vector store at the accepting edge; the
//  registered vector word is multiplied into the stage 2 product register,
//  and that product is accumulated, a row's last sum going to the output
//  register. The accumulator updates in a single stage, so consecutive nonzeros need no interlock.
//  Reset clears the pipeline, row sum and row counter; the vector store is
//  not cleared. Beats that give no result keep flowing while a result waits.
//
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // index, value
    input  logic [spmv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [spmv_pkg::CMD_W-1:0]      s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_number, row_sum
    output logic [spmv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                            m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    import spmv_pkg::*;

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);

    // Input fields
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic               in_accept;
    logic               in_range;
    logic [ADDR_W-1:0]  ram_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    assign in_index  = s_axis_tdata[INDEX_W-1:0];
    assign in_value  = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_range  = (32'(in_index) < 32'(VECTOR_DEPTH));
    assign ram_addr  = ADDR_W'(in_index);

    // Stage 1: vector word arriving from the store
    logic               v1_reg;
    spmv_ctrl_t         ctrl1_reg;
    logic [VALUE_W-1:0] val1_reg;

    // Stage 2: product ready for accumulation
    logic               v2_reg;
    logic [CMD_W-1:0]   cmd2_reg;
    logic               last2_reg;
    logic [SUM_W-1:0]   prod2_reg;

    // Accumulator and row state
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic               clip_reg;
    logic               clip_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;

    // Output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_sat_reg;

    // Flow control
    logic               out_free;
    logic               emit2;
    logic               stall2;
    logic               fire2;
    logic               en2;
    logic               en1;

    // Saturating add
    logic [SUM_W-1:0]   add_raw;
    logic               add_ovf;
    logic [SUM_W-1:0]   add_sat;

    // Multiplier operands
    logic signed [VALUE_W-1:0] mul_x;
    logic signed [VALUE_W-1:0] mul_a;
    logic signed [SUM_W-1:0]   mul_p;

    // Vector store
    spmv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_store (
        .clk     (clk),
        .wr_en   (in_accept && (s_axis_tuser == CMD_LOAD) && in_range),
        .wr_addr (ram_addr),
        .wr_data (in_value),
        .rd_en   (in_accept && (s_axis_tuser == CMD_NONZERO)),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    // Hold stages only behind a result that cannot leave
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit2         = (cmd2_reg == CMD_EMPTY_ROW) ||
                           ((cmd2_reg == CMD_NONZERO) && last2_reg);
    assign stall2        = v2_reg && emit2 && !out_free;
    assign fire2         = v2_reg && !stall2;
    assign en2           = !stall2;
    assign en1           = !(v1_reg && stall2);
    assign s_axis_tready = en1;

    // Advance stage 1: drop loads and unknown commands here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_accept &&
                      ((s_axis_tuser == CMD_NONZERO) || (s_axis_tuser == CMD_EMPTY_ROW));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ctrl1_reg.cmd      <= s_axis_tuser;
            ctrl1_reg.last     <= s_axis_tlast;
            ctrl1_reg.in_range <= in_range;
            val1_reg           <= in_value;
        end
    end

    // Multiply: an out-of-range column reads zero
    assign mul_x = ctrl1_reg.in_range ? $signed(ram_rd_data) : '0;
    assign mul_a = $signed(val1_reg);
    assign mul_p = SUM_W'(mul_x) * SUM_W'(mul_a);

    // Advance stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            cmd2_reg  <= ctrl1_reg.cmd;
            last2_reg <= ctrl1_reg.last;
            prod2_reg <= mul_p;
        end
    end

    // Saturating accumulate
    assign add_raw = sum_reg + prod2_reg;
    assign add_ovf = (sum_reg[SUM_W-1] == prod2_reg[SUM_W-1]) &&
                     (add_raw[SUM_W-1] != sum_reg[SUM_W-1]);
    assign add_sat = add_ovf ? (sum_reg[SUM_W-1] ? SUM_MIN : SUM_MAX) : add_raw;

    // Next row state
    always_comb
    begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        row_next  = row_reg;
        if (fire2)
        begin
            case (cmd2_reg)
                CMD_NONZERO:
                begin
                    if (last2_reg)
                    begin
                        sum_next  = '0;
                        clip_next = 1'b0;
                        row_next  = row_reg + 1'b1;
                    end
                    else
                    begin
                        sum_next  = add_sat;
                        clip_next = clip_reg || add_ovf;
                    end
                end
                CMD_EMPTY_ROW:
                begin
                    row_next = row_reg + 1'b1;
                end
                default:
                begin
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            clip_reg <= clip_next;
            row_reg  <= row_next;
        end
    end

    // Output register: load on an emitting beat, clear when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire2 && emit2)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire2 && emit2)
        begin
            out_row_reg <= row_reg;
            if (cmd2_reg == CMD_NONZERO)
            begin
                out_sum_reg <= add_sat;
                out_sat_reg <= clip_reg || add_ovf;
            end
            else
            begin
                out_sum_reg <= '0;
                out_sat_reg <= 1'b0;
            end
        end
    end

    // Drive the master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-ROW_W-SUM_W){1'b0}}, out_sum_reg, out_row_reg};

endmodule

[bench/tb_csr_sparse_matrix_vector_multiply.sv]
// ============================================================================
// tb_csr_sparse_matrix_vector_multiply
// Self-checking bench for the CSR sparse matrix-vector multiply block.
// Loads vector elements and streams rows of nonzeros, empty rows and ignored
// commands. A scoreboard class keeps its own vector store, saturating Q32.32
// row sum and row counter, and checks every row result in order. Both stream
// sides idle in random bursts.
// ============================================================================

module tb_csr_sparse_matrix_vector_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import spmv_pkg::*;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [SUM_W-1:0] sum;
        logic             clipped;
    } row_result_t;

    class spmv_scoreboard;
        logic [VALUE_W-1:0] vec_mem [VECTOR_DEPTH_DEFAULT];
        logic [SUM_W-1:0]   row_acc;
        logic               row_clip;
        logic [ROW_W-1:0]   row_no;
        row_result_t        pending [$];
        int                 errors;
        int                 rows_noted;

        function new();
            foreach (vec_mem[i])
                vec_mem[i] = '0;
            row_acc    = '0;
            row_clip   = 1'b0;
            row_no     = '0;
            errors     = 0;
            rows_noted = 0;
        endfunction

        // Queue a finished row and advance the row number
        function void close_row(logic [SUM_W-1:0] sum, logic clipped);
            row_result_t res;
            res.row     = row_no;
            res.sum     = sum;
            res.clipped = clipped;
            pending.push_back(res);
            row_no     = row_no + 1'b1;
            rows_noted = rows_noted + 1;
        endfunction

        // Apply one accepted input beat to the predicted state
        function void note_beat(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                logic [VALUE_W-1:0] val, logic last);
            logic [SUM_W-1:0] prod;
            logic [SUM_W-1:0] total;
            if (cmd == CMD_LOAD)
            begin
                vec_mem[idx] = val;
            end
            else if (cmd == CMD_NONZERO)
            begin
                prod  = longint'($signed(vec_mem[idx])) * longint'($signed(val));
                total = row_acc + prod;
                // Clamp on signed overflow: same operand signs, different result sign
                if (row_acc[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != row_acc[SUM_W-1])
                begin
                    total    = row_acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
                    row_clip = 1'b1;
                end
                row_acc = total;
                if (last)
                begin
                    close_row(row_acc, row_clip);
                    row_acc  = '0;
                    row_clip = 1'b0;
                end
            end
            else if (cmd == CMD_EMPTY_ROW)
            begin
                close_row('0, 1'b0);
            end
        endfunction

        task report_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
            $display("mismatch %0s: got %h expected %h", what, got, want);
            errors = errors + 1;
        endtask

        // Compare one accepted output beat with the oldest expected row
        task check_row(logic [ROW_W-1:0] row, logic [SUM_W-1:0] sum, logic clipped);
            row_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected row result", {54'd0, row}, '0);
            end
            else
            begin
                want = pending.pop_front();
                if (row !== want.row)
                    report_mismatch("row_number", {54'd0, row}, {54'd0, want.row});
                if (sum !== want.sum)
                    report_mismatch("row_sum", sum, want.sum);
                if (clipped !== want.clipped)
                    report_mismatch("saturated", {63'd0, clipped}, {63'd0, want.clipped});
            end
        endtask
    endclass

    localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
    localparam logic [VALUE_W-1:0] VAL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_ONE     = 32'h0001_0000;
    localparam int                 CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    spmv_scoreboard        board;
    bit                    col_loaded [VECTOR_DEPTH_DEFAULT];
    logic [INDEX_W-1:0]    loaded_cols [$];
    bit                    idle_on;
    int                    items_sent;
    int                    cycles = 0;
    int                    stall_left = 0;

    csr_sparse_matrix_vector_multiply u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: hold tready low in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 11) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check output beats while the bus is stable between edges
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.check_row(m_axis_tdata[ROW_W-1:0], m_axis_tdata[ROW_W+SUM_W-1:ROW_W],
                            m_axis_tuser);
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2:       v = $urandom_range(0, 1) ? VAL_ONE : -VAL_ONE;
            3:       v = $urandom_range(0, 1) ? 32'($urandom_range(0, 'h3FFFF))
                                              : -32'($urandom_range(0, 'h3FFFF));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Drive one beat from a rising edge; return at the edge that accepts it, or after the idle burst that may follow
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                             logic [VALUE_W-1:0] val, logic last);
        int gap;
        s_axis_tdata  <= {6'd0, val, idx};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(negedge clk);
        while (s_axis_tready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        board.note_beat(cmd, idx, val, last);
        items_sent = items_sent + 1;
        // Idle the sender for a burst now and then
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_element(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
        send_beat(CMD_LOAD, idx, val, 1'($urandom));
        if (!col_loaded[idx])
        begin
            col_loaded[idx] = 1'b1;
            loaded_cols.push_back(idx);
        end
    endtask

    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int len;
        bit paused;
        board         = new();
        items_sent    = 0;
        idle_on       = 1'b1;
        paused        = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        s_axis_tlast  <= 1'b0;
        s_axis_tvalid <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme elements at both ends of the store
        load_element(10'd0, VAL_MAX);
        load_element(10'd1023, VAL_MIN);
        load_element(10'd1, VAL_ONE);
        load_element(10'd2, 32'hFFFF_FFFF);
        // Plain row of two nonzeros
        send_beat(CMD_NONZERO, 10'd1, 32'h0002_0000, 1'b0);
        send_beat(CMD_NONZERO, 10'd2, VAL_MIN, 1'b1);
        send_beat(CMD_EMPTY_ROW, 10'd0, 32'd0, 1'b0);
        // Positive saturation, an empty row in between, flag kept to row end
        send_beat(CMD_NONZERO, 10'd1023, VAL_MIN, 1'b0);
        send_beat(CMD_NONZERO, 10'd1023, VAL_MIN, 1'b0);
        send_beat(CMD_EMPTY_ROW, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_beat(CMD_NONZERO, 10'd2, VAL_MAX, 1'b1);
        // Negative saturation
        send_beat(CMD_NONZERO, 10'd0, VAL_MIN, 1'b0);
        send_beat(CMD_NONZERO, 10'd0, VAL_MIN, 1'b0);
        send_beat(CMD_NONZERO, 10'd0, VAL_MIN, 1'b1);
        // Unknown command, then zero element and zero value
        send_beat(CMD_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        load_element(10'd3, 32'd0);
        send_beat(CMD_NONZERO, 10'd3, VAL_MAX, 1'b1);
        send_beat(CMD_NONZERO, 10'd0, 32'd0, 1'b1);
        drain_rows();

        // Random rows; run on until the row number has wrapped
        while (items_sent < 1500 || board.rows_noted < 1030)
        begin
            idle_on = !(items_sent >= 1300 || (items_sent >= 400 && items_sent < 550));
            if (!paused && items_sent >= 700)
            begin
                drain_rows();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                load_element(10'($urandom), pick_value());
            end
            else if (pick < 11)
            begin
                send_beat(CMD_UNUSED, 10'($urandom), $urandom, 1'($urandom));
            end
            else if (pick < 55)
            begin
                send_beat(CMD_EMPTY_ROW, 10'($urandom), $urandom, 1'($urandom));
            end
            else
            begin
                len = $urandom_range(1, 2);
                for (int k = 0; k < len; k++)
                begin
                    // Slip an empty row or a load in before a nonzero of the row
                    case ($urandom_range(0, 11))
                        0:       send_beat(CMD_EMPTY_ROW, 10'($urandom), $urandom, 1'b0);
                        1:       load_element(10'($urandom), pick_value());
                        default: ;
                    endcase
                    send_beat(CMD_NONZERO, loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
                              pick_value(), k == len - 1);
                end
            end
        end

        // Drain and let the pipeline settle
        drain_rows();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
